>>> hdl/dsls_pkg.sv
package dsls_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND
  } state_e;

  // request kinds (tuser)
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // line styles
  localparam logic [2:0] STYLE_SOLID   = 3'd1;
  localparam logic [2:0] STYLE_DASH    = 3'd2;
  localparam logic [2:0] STYLE_DOT     = 3'd3;
  localparam logic [2:0] STYLE_DASHDOT = 3'd4;

  // pattern geometry
  localparam int unsigned DASH_EVERY  = 5;
  localparam int unsigned DOT_EVERY   = 10;
  localparam int unsigned PATTERN_LEN = 20;
  localparam int unsigned DOT_POS     = 12;

  localparam int unsigned PHASE_W = $clog2(PATTERN_LEN);
  typedef logic [PHASE_W-1:0] phase_t;

  // plot flag from style and step position within the 20-step pattern
  function automatic logic plot_for(logic [2:0] style, phase_t ph);
    logic r;
    unique case (style)
      STYLE_SOLID:   r = 1'b1;
      STYLE_DASH:    r = (ph == '0) || (ph == PHASE_W'(DASH_EVERY)) ||
                         (ph == PHASE_W'(2 * DASH_EVERY)) ||
                         (ph == PHASE_W'(3 * DASH_EVERY));
      STYLE_DOT:     r = (ph == '0) || (ph == PHASE_W'(DOT_EVERY));
      STYLE_DASHDOT: r = (ph < PHASE_W'(DASH_EVERY)) || (ph == PHASE_W'(DOT_POS));
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/dda_styled_line_stepper.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid / tready        tdata: x_start, y_start, x_end, y_end, style
//                                       tuser: func (0 start, 1 step)
// m_axis    out  tvalid / tready        tdata: px, py; tuser: plot, error; tlast: last
//
// A step request's point is registered in the output register when it is taken.
// A start request gives point 0 at once, then a shared restoring divider works out
// the x and y increments one quotient bit per cycle, x first and then y, each with
// a rounding step after its quotient bits, while no request is taken.
// Reset (rst_ni low) leaves the block idle with no result pending; no clearing pass.
// A request is taken only while the output register is empty or being drained.
module dda_styled_line_stepper #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // x_start, y_start, x_end, y_end, style (lowest first), zero padded
  input  logic [((4*COORD_BITS+3+7)/8)*8-1:0]    s_axis_tdata_i,
  // func
  input  logic                                   s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // px, py (lowest first), zero padded
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata_o,
  // plot, error (lowest first)
  output logic [1:0]                             m_axis_tuser_o,
  output logic                                   m_axis_tlast_o
);

  import dsls_pkg::*;

  localparam int unsigned OUT_W  = ((2*COORD_BITS+7)/8)*8;
  localparam int unsigned D_W    = COORD_BITS + 1;            // signed delta
  localparam int unsigned ACC_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned INC_W  = FRAC_BITS + 2;
  localparam int unsigned Q_W    = FRAC_BITS + 1;             // quotient up to 2^FRAC_BITS
  localparam int unsigned CNT_W  = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);
  localparam logic [ACC_W-1:0] RND_POS  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] RND_NEG  = RND_POS - ACC_W'(1);

  // ---------------------------------------------------------------------------
  // Request unpack
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
  logic [2:0]                   in_style;

  assign xs       = s_axis_tdata_i[0*COORD_BITS +: COORD_BITS];
  assign ys       = s_axis_tdata_i[1*COORD_BITS +: COORD_BITS];
  assign xe       = s_axis_tdata_i[2*COORD_BITS +: COORD_BITS];
  assign ye       = s_axis_tdata_i[3*COORD_BITS +: COORD_BITS];
  assign in_style = s_axis_tdata_i[4*COORD_BITS +: 3];

  // deltas and the major-axis length
  logic signed [D_W-1:0]   dx, dy;
  logic [D_W-1:0]          dx_abs_w, dy_abs_w;
  logic [COORD_BITS-1:0]   dx_abs, dy_abs, len;

  assign dx       = D_W'(xe) - D_W'(xs);
  assign dy       = D_W'(ye) - D_W'(ys);
  assign dx_abs_w = dx[D_W-1] ? -dx : dx;
  assign dy_abs_w = dy[D_W-1] ? -dy : dy;
  assign dx_abs   = dx_abs_w[COORD_BITS-1:0];
  assign dy_abs   = dy_abs_w[COORD_BITS-1:0];
  assign len      = (dx_abs > dy_abs) ? dx_abs : dy_abs;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic                    busy_q;
  logic [COORD_BITS-1:0]   step_idx_q, step_tot_q;
  phase_t                  phase_q;
  logic [2:0]              style_q;
  logic [ACC_W-1:0]        x_acc_q, y_acc_q;
  logic [INC_W-1:0]        x_inc_q, y_inc_q;

  // divider
  logic                    axis_q;                 // 0 x, 1 y
  logic [CNT_W-1:0]        cnt_q;
  logic [COORD_BITS-1:0]   rem_q;
  logic [Q_W-1:0]          quo_q;
  logic [COORD_BITS-1:0]   ady_q;
  logic                    sx_q, sy_q;

  // output register
  logic                    ovalid_q;
  logic [COORD_BITS-1:0]   px_q, py_q;
  logic                    plot_q, last_q, err_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic in_ready, accept, start_line, div_en, rnd_en;

  assign accept     = s_axis_tvalid_i && in_ready;
  assign start_line = accept && (s_axis_tuser_i == FUNC_START) && (len != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_line) state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CNT_LAST) state_d = ST_ROUND;
      ST_ROUND: state_d = axis_q ? ST_IDLE : ST_DIV;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_en   = 1'b0;
    rnd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready = !ovalid_q || m_axis_tready_i;
      ST_DIV:   div_en   = 1'b1;
      ST_ROUND: rnd_en   = 1'b1;
      default:  ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared divider: |d| * 2^FRAC_BITS / len, one quotient bit a cycle.
  // First cycle compares |d| itself (it may equal len), later ones 2*rem.
  // ---------------------------------------------------------------------------
  logic [COORD_BITS:0]   trial;
  logic                  ge;
  logic [COORD_BITS:0]   trial_sub;
  logic                  round_up;
  logic [INC_W-1:0]      mag_q, inc_new;
  logic                  sign_cur;

  assign trial     = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge        = trial >= {1'b0, step_tot_q};
  assign trial_sub = trial - {1'b0, step_tot_q};
  // round to nearest, half up on magnitude
  assign round_up  = {rem_q, 1'b0} >= {1'b0, step_tot_q};
  assign mag_q     = {1'b0, quo_q} + INC_W'(round_up);
  assign sign_cur  = axis_q ? sy_q : sx_q;
  assign inc_new   = sign_cur ? -mag_q : mag_q;

  // ---------------------------------------------------------------------------
  // Step datapath
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0]      x_sum, y_sum, x_rnd, y_rnd;
  logic [COORD_BITS-1:0] idx_next;
  phase_t                phase_next;

  assign x_sum = x_acc_q + {{(ACC_W-INC_W){x_inc_q[INC_W-1]}}, x_inc_q};
  assign y_sum = y_acc_q + {{(ACC_W-INC_W){y_inc_q[INC_W-1]}}, y_inc_q};
  // half away from zero: negative values take half minus one before the floor
  assign x_rnd = x_sum + (x_sum[ACC_W-1] ? RND_NEG : RND_POS);
  assign y_rnd = y_sum + (y_sum[ACC_W-1] ? RND_NEG : RND_POS);

  assign idx_next   = step_idx_q + COORD_BITS'(1);
  assign phase_next = (phase_q == PHASE_W'(PATTERN_LEN - 1)) ? '0 : phase_q + PHASE_W'(1);

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      axis_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      if (accept) begin
        if (s_axis_tuser_i == FUNC_START) begin
          busy_q <= (len != '0);
        end else if (busy_q && (idx_next == step_tot_q)) begin
          busy_q <= 1'b0;
        end
      end
      if (start_line) begin
        axis_q <= 1'b0;
        cnt_q  <= '0;
      end else if (div_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (rnd_en) begin
        axis_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line state, divider and output payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (start_line) begin
      x_acc_q    <= {xs[COORD_BITS-1], xs, {FRAC_BITS{1'b0}}};
      y_acc_q    <= {ys[COORD_BITS-1], ys, {FRAC_BITS{1'b0}}};
      step_idx_q <= '0;
      step_tot_q <= len;
      phase_q    <= '0;
      style_q    <= in_style;
      rem_q      <= dx_abs;
      ady_q      <= dy_abs;
      sx_q       <= dx[D_W-1];
      sy_q       <= dy[D_W-1];
    end else if (accept && busy_q) begin
      x_acc_q    <= x_sum;
      y_acc_q    <= y_sum;
      step_idx_q <= idx_next;
      phase_q    <= phase_next;
    end else if (div_en) begin
      rem_q <= ge ? trial_sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo_q <= {quo_q[Q_W-2:0], ge};
    end else if (rnd_en) begin
      if (axis_q) begin
        y_inc_q <= inc_new;
      end else begin
        x_inc_q <= inc_new;
        rem_q   <= ady_q;
      end
    end

    if (accept) begin
      px_q   <= '0;
      py_q   <= '0;
      plot_q <= 1'b0;
      last_q <= 1'b1;
      err_q  <= 1'b0;
      if (s_axis_tuser_i == FUNC_START) begin
        if (len == '0) begin
          err_q <= 1'b1;
        end else begin
          px_q   <= xs;
          py_q   <= ys;
          plot_q <= plot_for(in_style, '0);
          last_q <= 1'b0;
        end
      end else if (busy_q) begin
        px_q   <= x_rnd[FRAC_BITS +: COORD_BITS];
        py_q   <= y_rnd[FRAC_BITS +: COORD_BITS];
        plot_q <= plot_for(style_q, phase_next);
        last_q <= (idx_next == step_tot_q);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = OUT_W'({py_q, px_q});
  assign m_axis_tuser_o  = {err_q, plot_q};
  assign m_axis_tlast_o  = last_q;

endmodule
